[rtl/sti_pkg.sv]
// Shared types and constants for the UV-sphere triangle index sequencer.
// Holds the region codes, the configuration and triangle structs and the index mask.
// No dependencies.
`timescale 1ns / 1ps

package sti_pkg;

    // Width of the vertex arithmetic; indices wrap modulo 2^IndexBits.
    localparam int IndexBits = 16;
    localparam int OutBits   = 16;

    // Keeps the low min(IndexBits, OutBits) bits of a 16-bit index.
    localparam logic [OutBits-1:0] IdxMask =
        (IndexBits >= OutBits) ? {OutBits{1'b1}}
                               : OutBits'((64'd1 << IndexBits) - 64'd1);

    localparam int AddrBits = 3;

    // Register select is bit 2 of the byte address.
    typedef enum logic
    {
        CFG_NUM_LAYERS  = 1'b0,
        CFG_RING_POINTS = 1'b1
    } cfg_sel_t;

    typedef enum logic [1:0]
    {
        REGION_TOP    = 2'd0,
        REGION_BAND   = 2'd1,
        REGION_BOTTOM = 2'd2
    } region_t;

    typedef struct packed
    {
        logic [7:0] num_layers;
        logic [7:0] ring_points;
    } cfg_t;

    typedef struct packed
    {
        logic [OutBits-1:0] vertex_a;
        logic [OutBits-1:0] vertex_b;
        logic [OutBits-1:0] vertex_c;
        logic               last_triangle;
    } tri_t;

endpackage

[rtl/sti_cfg_regs.sv]
// APB-style configuration registers for the triangle index sequencer.
// Uses sti_pkg for the register select codes and the configuration struct.
`timescale 1ns / 1ps

module sti_cfg_regs
    import sti_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrBits-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output cfg_t                cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_sel_t sel;
    logic     wr_en;

    assign pready = 1'b1;
    assign sel    = cfg_sel_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                CFG_NUM_LAYERS:  cfg_next.num_layers  = pwdata[7:0];
                CFG_RING_POINTS: cfg_next.ring_points = pwdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            CFG_NUM_LAYERS:  prdata = {24'd0, cfg_reg.num_layers};
            CFG_RING_POINTS: prdata = {24'd0, cfg_reg.ring_points};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_layers  <= 8'd1;
            cfg_reg.ring_points <= 8'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/sti_tri_seq.sv]
// Sequencer state and triangle generation: top-cap fan, band quads, bottom-cap fan.
// Uses sti_pkg for region codes, configuration and triangle structs.
`timescale 1ns / 1ps

module sti_tri_seq
    import sti_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic advance,
    input  logic restart,
    output tri_t tri_out
);

    region_t     region_reg,        region_next;
    logic [15:0] ring_base_reg,     ring_base_next;
    logic [7:0]  ring_position_reg, ring_position_next;
    logic [7:0]  layer_count_reg,   layer_count_next;
    logic        second_half_reg,   second_half_next;

    // State as seen by this item, after an optional restart.
    region_t     region;
    logic [15:0] rb;
    logic [7:0]  pos;
    logic [7:0]  lc;
    logic        half;

    logic [7:0]  n;
    logic [7:0]  lay;
    logic        wrap;
    logic [7:0]  pn;
    logic [7:0]  lc_inc;
    logic [15:0] rb_pos;
    logic [15:0] rb_pn;
    logic [15:0] rb_n;
    logic [15:0] va;
    logic [15:0] vb;
    logic [15:0] vc;
    logic        last;

    always_comb
    begin
        if (restart)
        begin
            region = REGION_TOP;
            rb     = 16'd1;
            pos    = 8'd0;
            lc     = 8'd0;
            half   = 1'b0;
        end
        else
        begin
            region = region_reg;
            rb     = ring_base_reg;
            pos    = ring_position_reg;
            lc     = layer_count_reg;
            half   = second_half_reg;
        end
    end

    // Values below range act as the smallest legal mesh.
    assign n   = (cfg.ring_points < 8'd3) ? 8'd3 : cfg.ring_points;
    assign lay = (cfg.num_layers == 8'd0) ? 8'd1 : cfg.num_layers;

    assign wrap   = ({1'b0, pos} + 9'd1) >= {1'b0, n};
    assign pn     = wrap ? 8'd0 : pos + 8'd1;
    assign lc_inc = lc + 8'd1;
    assign rb_pos = rb + {8'd0, pos};
    assign rb_pn  = rb + {8'd0, pn};
    assign rb_n   = rb + {8'd0, n};

    always_comb
    begin
        region_next        = region;
        ring_base_next     = rb;
        ring_position_next = pn;
        layer_count_next   = lc;
        second_half_next   = half;
        last               = 1'b0;
        case (region)
            REGION_BAND:
            begin
                va = rb_pos;
                vc = rb_n + {8'd0, pn};
                if (!half)
                begin
                    vb                 = rb_pos + {8'd0, n};
                    second_half_next   = 1'b1;
                    ring_position_next = pos;
                end
                else
                begin
                    vb               = rb_pn;
                    second_half_next = 1'b0;
                    if (wrap)
                    begin
                        ring_base_next   = rb_n;
                        layer_count_next = lc_inc;
                        if (lc_inc >= lay - 8'd1)
                        begin
                            region_next = REGION_BOTTOM;
                        end
                    end
                end
            end
            REGION_BOTTOM:
            begin
                va = rb_pos;
                vb = rb_pn;
                vc = rb_n;
                if (wrap)
                begin
                    last             = 1'b1;
                    region_next      = REGION_TOP;
                    ring_base_next   = 16'd1;
                    layer_count_next = 8'd0;
                    second_half_next = 1'b0;
                end
            end
            default:
            begin
                // Top cap; the unused region code behaves the same way.
                va = 16'd0;
                vb = rb_pos;
                vc = rb_pn;
                if (wrap)
                begin
                    second_half_next = 1'b0;
                    layer_count_next = 8'd0;
                    region_next      = (lay == 8'd1) ? REGION_BOTTOM : REGION_BAND;
                end
            end
        endcase
    end

    assign tri_out.vertex_a      = va & IdxMask;
    assign tri_out.vertex_b      = vb & IdxMask;
    assign tri_out.vertex_c      = vc & IdxMask;
    assign tri_out.last_triangle = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg        <= REGION_TOP;
            ring_base_reg     <= 16'd1;
            ring_position_reg <= 8'd0;
            layer_count_reg   <= 8'd0;
            second_half_reg   <= 1'b0;
        end
        else if (advance)
        begin
            region_reg        <= region_next;
            ring_base_reg     <= ring_base_next;
            ring_position_reg <= ring_position_next;
            layer_count_reg   <= layer_count_next;
            second_half_reg   <= second_half_next;
        end
    end

endmodule

[rtl/sti_out_buf.sv]
// Output register with a skid stage for triangle items.
// Uses sti_pkg for the triangle struct.
`timescale 1ns / 1ps

module sti_out_buf
    import sti_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  tri_t data_in,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output tri_t data_out
);

    logic out_valid_reg;
    logic skid_valid_reg;
    tri_t out_data_reg;
    tri_t skid_data_reg;
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || load;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // A load never coincides with a full skid stage, since the input is stalled then.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : data_in;
        end
        else if (load)
        begin
            skid_data_reg <= data_in;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;

endmodule

[rtl/sphere_triangle_index_generator.sv]
// Top level of the UV-sphere triangle index sequencer.
// Instantiates sti_cfg_regs, sti_tri_seq and sti_out_buf; uses sti_pkg.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  restart
//   out       output     out_valid/out_stall  vertex_a, vertex_b, vertex_c, last_triangle
//   config    input      APB psel/penable     num_layers (0x0), ring_points (0x4)
//
// One triangle per item and one item per cycle while in_stall is low; each accepted item's
// triangle, computed from the sequencer counters by two levels of 16-bit adders, is registered.
// Reset puts the sequence at the first top-cap triangle, num_layers 1, ring_points 3.
// in_stall is registered: it rises only when the skid stage holds an item behind a
// stalled output register, so one extra item is taken after out_stall rises.
`timescale 1ns / 1ps

module sphere_triangle_index_generator
    import sti_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrBits-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OutBits-1:0]  vertex_a,
    output logic [OutBits-1:0]  vertex_b,
    output logic [OutBits-1:0]  vertex_c,
    output logic                last_triangle
);

    cfg_t cfg;
    tri_t tri_new;
    tri_t tri_out;
    logic accept;
    logic buf_full;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    sti_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sti_tri_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (accept),
        .restart (restart),
        .tri_out (tri_new)
    );

    sti_out_buf u_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .data_in   (tri_new),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (tri_out)
    );

    assign vertex_a      = tri_out.vertex_a;
    assign vertex_b      = tri_out.vertex_b;
    assign vertex_c      = tri_out.vertex_c;
    assign last_triangle = tri_out.last_triangle;

endmodule

[tb/sphere_triangle_index_generator_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sphere_triangle_index_generator: directed and random restart items,
// APB register phases, and a built-in model of the triangle order that checks every result.
// Depends on sti_pkg and the sphere_triangle_index_generator RTL.

module sphere_triangle_index_generator_test;
    import sti_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 100;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [AddrBits-1:0] paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                restart = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [OutBits-1:0]  vertex_a;
    logic [OutBits-1:0]  vertex_b;
    logic [OutBits-1:0]  vertex_c;
    logic                last_triangle;

    // Register mirror and the sequencer position as the mesh walk sees it.
    logic [7:0]  mirror_layers = 8'd1;
    logic [7:0]  mirror_ring = 8'd3;
    region_t     walk_region;
    logic [15:0] walk_base;
    logic [7:0]  walk_pos;
    logic [7:0]  walk_bands;
    logic        walk_second;

    logic        restart_queue[$];
    tri_t        awaited_tris[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned in_gap = 0;
    int unsigned stall_left = 0;
    logic        in_quiet = 1'b0;
    logic        out_quiet = 1'b0;

    sphere_triangle_index_generator DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_error(input string what);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("%0t ns  mismatch: %s", $time, what);
    endtask

    function automatic void rewind_walk();
        walk_region = REGION_TOP;
        walk_base   = 16'd1;
        walk_pos    = 8'd0;
        walk_bands  = 8'd0;
        walk_second = 1'b0;
    endfunction

    // Emits the triangle for one accepted item and advances the walk over the mesh.
    function automatic tri_t next_triangle(input logic restart_bit);
        logic [15:0] n;
        logic [15:0] lay;
        logic [15:0] pos;
        logic [15:0] pn;
        logic [15:0] rb;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic        wrap;
        logic        last;
        tri_t        t;
        if (restart_bit)
            rewind_walk();
        n    = (mirror_ring < 8'd3) ? 16'd3 : {8'd0, mirror_ring};
        lay  = (mirror_layers < 8'd1) ? 16'd1 : {8'd0, mirror_layers};
        pos  = {8'd0, walk_pos};
        rb   = walk_base;
        wrap = (pos + 16'd1) >= n;
        pn   = wrap ? 16'd0 : pos + 16'd1;
        last = 1'b0;
        case (walk_region)
            REGION_BAND:
            begin
                a = rb + pos;
                c = rb + n + pn;
                if (!walk_second)
                begin
                    b = rb + pos + n;
                    walk_second = 1'b1;
                end
                else
                begin
                    b = rb + pn;
                    walk_second = 1'b0;
                    if (wrap)
                    begin
                        walk_pos   = 8'd0;
                        walk_base  = rb + n;
                        walk_bands = walk_bands + 8'd1;
                        if ({8'd0, walk_bands} >= lay - 16'd1)
                            walk_region = REGION_BOTTOM;
                    end
                    else
                        walk_pos = pn[7:0];
                end
            end
            REGION_BOTTOM:
            begin
                a = rb + pos;
                b = rb + pn;
                c = rb + n;
                if (wrap)
                begin
                    last = 1'b1;
                    rewind_walk();
                end
                else
                    walk_pos = pn[7:0];
            end
            default:
            begin
                a = 16'd0;
                b = rb + pos;
                c = rb + pn;
                if (wrap)
                begin
                    walk_pos    = 8'd0;
                    walk_second = 1'b0;
                    walk_bands  = 8'd0;
                    walk_region = (lay <= 16'd1) ? REGION_BOTTOM : REGION_BAND;
                end
                else
                    walk_pos = pn[7:0];
            end
        endcase
        t.vertex_a      = a & IdxMask;
        t.vertex_b      = b & IdxMask;
        t.vertex_c      = c & IdxMask;
        t.last_triangle = last;
        return t;
    endfunction

    // Mostly back-to-back or short pauses, now and then a long one.
    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    task automatic check_register(input cfg_sel_t sel);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[7:0] !== (sel == CFG_NUM_LAYERS ? mirror_layers : mirror_ring))
            report_error($sformatf("register %s reads %0d", sel.name(), prdata[7:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Upper bits of the write data are random; only the low byte is kept.
    task automatic set_register(input cfg_sel_t sel, input logic [7:0] value);
        logic [31:0] word;
        word      = $urandom();
        word[7:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == CFG_NUM_LAYERS)
            mirror_layers = value;
        else
            mirror_ring = value;
        check_register(sel);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (restart_queue.size() != 0 || in_valid || awaited_tris.size() != 0);
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                awaited_tris.push_back(next_triangle(restart));
            if (!in_valid || !in_stall)
            begin
                if (in_gap != 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (restart_queue.size() != 0)
                begin
                    in_valid <= 1'b1;
                    restart  <= restart_queue.pop_front();
                    in_gap   <= in_quiet ? 0 : pick_pause();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Triangle monitor and output back-pressure.
    always @(posedge clk or negedge rst_n)
    begin : triangle_monitor
        tri_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_tris.size() == 0)
                    report_error("triangle arrived with no item outstanding");
                else
                begin
                    want = awaited_tris.pop_front();
                    if (vertex_a !== want.vertex_a)
                        report_error($sformatf("vertex_a %0d, want %0d", vertex_a, want.vertex_a));
                    if (vertex_b !== want.vertex_b)
                        report_error($sformatf("vertex_b %0d, want %0d", vertex_b, want.vertex_b));
                    if (vertex_c !== want.vertex_c)
                        report_error($sformatf("vertex_c %0d, want %0d", vertex_c, want.vertex_c));
                    if (last_triangle !== want.last_triangle)
                        report_error($sformatf("last_triangle %b, want %b", last_triangle,
                                               want.last_triangle));
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else if (!out_quiet && $urandom_range(0, 99) < 30)
            begin
                out_stall  <= 1'b1;
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(4, 24)
                                                          : $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sphere_triangle_index_generator_test: errors");
            $finish;
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned burst;
        int unsigned pick;
        logic [7:0]  lay_v;
        logic [7:0]  ring_v;
        sent = 0;
        rewind_walk();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        check_register(CFG_NUM_LAYERS);
        check_register(CFG_RING_POINTS);

        // Reset geometry: a whole mesh, then restarts at the start and partway into the cap.
        @(negedge clk);
        restart_queue = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        wait_idle();

        // Out-of-range sizes fall back to one layer of three points.
        set_register(CFG_NUM_LAYERS, 8'd0);
        set_register(CFG_RING_POINTS, 8'd0);
        @(negedge clk);
        restart_queue = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
        wait_idle();

        set_register(CFG_NUM_LAYERS, 8'd255);
        set_register(CFG_RING_POINTS, 8'd255);
        @(negedge clk);
        restart_queue = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
        wait_idle();

        // Random phases: mostly small meshes that finish often, some at the size limits.
        // Registers change between phases, usually mid-mesh.
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                lay_v  = 8'($urandom_range(0, 5));
                ring_v = 8'($urandom_range(0, 7));
            end
            else if (pick == 7)
            begin
                lay_v  = 8'd255;
                ring_v = 8'($urandom_range(0, 4));
            end
            else if (pick == 8)
            begin
                lay_v  = 8'($urandom_range(0, 2));
                ring_v = 8'd255;
            end
            else
            begin
                lay_v  = 8'($urandom_range(0, 255));
                ring_v = 8'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 3) != 0)
                set_register(CFG_NUM_LAYERS, lay_v);
            if ($urandom_range(0, 3) != 0)
                set_register(CFG_RING_POINTS, ring_v);
            @(negedge clk);
            in_quiet  = ($urandom_range(0, 4) == 0);
            out_quiet = ($urandom_range(0, 4) == 0);
            burst = $urandom_range(20, 120);
            repeat (burst)
                restart_queue.push_back($urandom_range(0, 63) == 0);
            sent += burst;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("sphere_triangle_index_generator_test: clean");
        else
            $display("sphere_triangle_index_generator_test: errors");
        $finish;
    end

endmodule

[sim.f]
rtl/sti_pkg.sv
rtl/sti_cfg_regs.sv
rtl/sti_tri_seq.sv
rtl/sti_out_buf.sv
rtl/sphere_triangle_index_generator.sv
tb/sphere_triangle_index_generator_test.sv
